// File: design/fixed_block_free_list_allocator_unit_macros.svh
// Assertion macros used by the allocator top level.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBFLA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FBFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/fbfla_pkg.sv
package fbfla_pkg;

	localparam int POOL_DEPTH_DEF = 256;

	localparam int CNT_W      = 9;
	localparam int SIZE_W     = 16;
	localparam int OFF_W      = 24;
	localparam int FUNC_W     = 2;
	localparam int PROD_W     = CNT_W + SIZE_W;
	localparam int DIV_STEPS  = CNT_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = SIZE_W;
	localparam int S_DATA_W   = 32;
	localparam int S_PAD_W    = S_DATA_W - FUNC_W - OFF_W;
	localparam int M_DATA_W   = 40;
	localparam int M_PAD_W    = M_DATA_W - 1 - OFF_W - CNT_W;

	localparam logic [CNT_W-1:0]  MAX_BLOCKS_RST = 9'd256;
	localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = 16'd64;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ALLOC = 2'd0,
		FUNC_FREE  = 2'd1,
		FUNC_CHECK = 2'd2
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_BLOCKS = 1'b0,
		REG_BLOCK_SIZE = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TOUCH,
		ST_MUL,
		ST_EVAL,
		ST_POP,
		ST_DIV,
		ST_PUSH,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic touch;
		logic mul;
		logic pop_start;
		logic pop_finish;
		logic chk_res;
		logic div_start;
		logic div_step;
		logic push;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  can_pop;
		logic  last_pop;
		logic  free_ok;
		logic  div_last;
		logic  out_free;
	} dp_stat_t;

	// Number of usable blocks: the register value capped at the pool depth.
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] mb, input int depth);
		logic [CNT_W-1:0] res;
		res = mb;
		if (32'(mb) > depth) begin
			res = CNT_W'(depth);
		end
		return res;
	endfunction

endpackage

// File: design/fbfla_ram.sv
module fbfla_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: design/fbfla_dp.sv
module fbfla_dp import fbfla_pkg::*; #(
	parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  func_t                 in_func,
	input  logic [OFF_W-1:0]      in_offset,
	input  logic                  m_tready,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	output logic                  m_tvalid,
	output logic                  m_ok,
	output logic [OFF_W-1:0]      m_alloc_offset,
	output logic [CNT_W-1:0]      m_free_count
);

	localparam int AW = $clog2(POOL_DEPTH);
	localparam logic [CNT_W-1:0] RST_BLOCKS = eff_count(MAX_BLOCKS_RST, POOL_DEPTH);

	logic [CNT_W-1:0]  max_blocks_q;
	logic [SIZE_W-1:0] block_size_q;
	logic [CNT_W-1:0]  head_q;
	logic              head_valid_q;
	logic [CNT_W-1:0]  free_q;
	logic [CNT_W-1:0]  touched_q;
	logic              out_valid_q;
	logic [STEP_W-1:0] step_q;

	func_t             func_q;
	logic [OFF_W-1:0]  off_q;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] rem_q;
	logic [PROD_W-1:0] dvs_q;
	logic [CNT_W-1:0]  quo_q;
	logic              res_ok_q;
	logic [OFF_W-1:0]  res_aoff_q;
	logic              out_ok_q;
	logic [OFF_W-1:0]  out_aoff_q;
	logic [CNT_W-1:0]  out_free_q;

	logic [CNT_W-1:0]  n_blocks;
	logic [SIZE_W-1:0] bs;
	logic [CNT_W-1:0]  mb_new;
	logic [CNT_W-1:0]  n_new;
	logic              cfg_hit;
	logic [CNT_W-1:0]  mul_a;
	logic              in_span;
	logic              touch_wr;

	logic              ram_wr_en;
	logic [AW-1:0]     ram_wr_addr;
	logic [CNT_W-1:0]  ram_wr_data;
	logic [CNT_W-1:0]  ram_rd_data;

	assign n_blocks = eff_count(max_blocks_q, POOL_DEPTH);
	assign bs       = (block_size_q == '0) ? SIZE_W'(1) : block_size_q;
	assign mul_a    = (func_q == FUNC_ALLOC) ? head_q : n_blocks;
	assign in_span  = ({1'b0, off_q} < prod_q);
	assign touch_wr = cmd.touch && (touched_q < n_blocks);

	always_comb begin
		cfg_hit = 1'b0;
		mb_new  = max_blocks_q;
		case (cfg_reg_t'(cfg_index))
			REG_MAX_BLOCKS: begin
				cfg_hit = cfg_wr_en;
				mb_new  = cfg_data[CNT_W-1:0];
			end
			REG_BLOCK_SIZE: begin
				cfg_hit = cfg_wr_en;
			end
			default: begin
				cfg_hit = 1'b0;
			end
		endcase
		n_new = eff_count(mb_new, POOL_DEPTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_blocks_q <= MAX_BLOCKS_RST;
			block_size_q <= BLOCK_SIZE_RST;
			head_q       <= '0;
			head_valid_q <= (RST_BLOCKS != '0);
			free_q       <= RST_BLOCKS;
			touched_q    <= '0;
			out_valid_q  <= 1'b0;
			step_q       <= '0;
		end else begin
			if (cfg_hit) begin
				max_blocks_q <= mb_new;
				if (cfg_reg_t'(cfg_index) == REG_BLOCK_SIZE) begin
					block_size_q <= cfg_data;
				end
				head_q       <= '0;
				head_valid_q <= (n_new != '0);
				free_q       <= n_new;
				touched_q    <= '0;
			end else begin
				if (touch_wr) begin
					touched_q <= touched_q + 1'b1;
				end
				if (cmd.pop_start) begin
					free_q <= free_q - 1'b1;
					if (free_q == CNT_W'(1)) begin
						head_valid_q <= 1'b0;
					end
				end
				if (cmd.pop_finish) begin
					if (ram_rd_data < n_blocks) begin
						head_q <= ram_rd_data;
					end else begin
						head_valid_q <= 1'b0;
					end
				end
				if (cmd.push) begin
					head_q       <= quo_q;
					head_valid_q <= 1'b1;
					free_q       <= free_q + 1'b1;
				end
			end
			if (cmd.div_start) begin
				step_q <= STEP_W'(DIV_STEPS - 1);
			end else if (cmd.div_step) begin
				step_q <= step_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q     <= in_func;
			off_q      <= in_offset;
			res_ok_q   <= 1'b0;
			res_aoff_q <= '0;
		end
		if (cmd.mul) begin
			prod_q <= {{SIZE_W{1'b0}}, mul_a} * {{CNT_W{1'b0}}, bs};
		end
		if (cmd.pop_start) begin
			res_ok_q   <= 1'b1;
			res_aoff_q <= prod_q[OFF_W-1:0];
		end
		if (cmd.chk_res) begin
			res_ok_q <= in_span;
		end
		if (cmd.div_start) begin
			rem_q <= {1'b0, off_q};
			dvs_q <= {1'b0, bs, {(CNT_W-1){1'b0}}};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= dvs_q) begin
				rem_q <= rem_q - dvs_q;
				quo_q <= {quo_q[CNT_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[CNT_W-2:0], 1'b0};
			end
			dvs_q <= dvs_q >> 1;
		end
		if (cmd.push) begin
			res_ok_q <= 1'b1;
		end
		if (cmd.out_load) begin
			out_ok_q   <= res_ok_q;
			out_aoff_q <= res_aoff_q;
			out_free_q <= free_q;
		end
	end

	assign ram_wr_en   = touch_wr || cmd.push;
	assign ram_wr_addr = cmd.push ? AW'(quo_q) : AW'(touched_q);
	assign ram_wr_data = cmd.push ? (head_valid_q ? head_q : n_blocks) : (touched_q + 1'b1);

	fbfla_ram #(
		.WIDTH(CNT_W),
		.DEPTH(POOL_DEPTH)
	) u_link_ram (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_en  (cmd.pop_start),
		.rd_addr(AW'(head_q)),
		.rd_data(ram_rd_data)
	);

	assign stat.func     = func_q;
	assign stat.can_pop  = (free_q != '0) && head_valid_q && (head_q < n_blocks);
	assign stat.last_pop = (free_q == CNT_W'(1));
	assign stat.free_ok  = in_span && (free_q < n_blocks);
	assign stat.div_last = (step_q == '0);
	assign stat.out_free = !out_valid_q || m_tready;

	assign m_tvalid       = out_valid_q;
	assign m_ok           = out_ok_q;
	assign m_alloc_offset = out_aoff_q;
	assign m_free_count   = out_free_q;

endmodule

// File: design/fbfla_ctrl.sv
module fbfla_ctrl import fbfla_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	input  func_t    in_func,
	input  dp_stat_t stat,
	output logic     s_tready,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					case (in_func)
						FUNC_ALLOC: state_d = ST_TOUCH;
						FUNC_FREE:  state_d = ST_MUL;
						FUNC_CHECK: state_d = ST_MUL;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_TOUCH: begin
				cmd.touch = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				state_d = ST_DONE;
				case (stat.func)
					FUNC_ALLOC: begin
						if (stat.can_pop) begin
							cmd.pop_start = 1'b1;
							if (!stat.last_pop) begin
								state_d = ST_POP;
							end
						end
					end
					FUNC_FREE: begin
						if (stat.free_ok) begin
							cmd.div_start = 1'b1;
							state_d       = ST_DIV;
						end
					end
					FUNC_CHECK: begin
						cmd.chk_res = 1'b1;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_POP: begin
				cmd.pop_finish = 1'b1;
				state_d        = ST_DONE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: design/fixed_block_free_list_allocator_unit.sv
// Fixed-size block allocator with a free list kept in an on-chip link memory.
// Requests arrive on the s_ channel, one word per request: alloc, free or
// check. Each request yields exactly one result word on the m_ channel.
// The configuration port sets the block count and block size; any write
// re-initializes the free list, so write it only while no request is pending.
// The block takes one request at a time. An alloc steps through TOUCH,
// MUL, EVAL, POP and DONE, with POP taking the registered read of the link
// memory (POP is skipped when the alloc fails or hands out the last free
// block), a check or a rejected free through MUL, EVAL and DONE, an accepted
// free through MUL, EVAL, DIV, PUSH and DONE, and an unknown request to DONE;
// in DIV the 9-step shift-and-subtract divider turns the byte offset into a
// block index. A new request is taken in the cycle after the result is loaded.
// The result sits in an output register, so a request can be accepted while
// the previous result still waits; a stalled receiver holds it there and
// the next result waits inside the block until the register frees up.
// After reset all blocks are free, with 256 blocks of 64 bytes; the link
// memory is filled lazily by allocs, so no clearing pass is needed.
`include "fixed_block_free_list_allocator_unit_macros.svh"

module fixed_block_free_list_allocator_unit import fbfla_pkg::*; #(
	parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// func [1:0], block_offset [25:2], zero fill above
	input  logic [S_DATA_W-1:0]   s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// ok [0], alloc_offset [24:1], free_count [33:25], zero fill above
	output logic [M_DATA_W-1:0]   m_tdata
);

	dp_cmd_t          dp_cmd;
	dp_stat_t         dp_stat;
	func_t            in_func;
	logic             m_ok;
	logic [OFF_W-1:0] m_alloc_offset;
	logic [CNT_W-1:0] m_free_count;
	logic [7:0]       step_cmds;

	assign in_func = func_t'(s_tdata[FUNC_W-1:0]);

	fbfla_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.in_func (in_func),
		.stat    (dp_stat),
		.s_tready(s_tready),
		.cmd     (dp_cmd)
	);

	fbfla_dp #(
		.POOL_DEPTH(POOL_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_func       (in_func),
		.in_offset     (s_tdata[FUNC_W+OFF_W-1:FUNC_W]),
		.m_tready      (m_tready),
		.cmd           (dp_cmd),
		.stat          (dp_stat),
		.m_tvalid      (m_tvalid),
		.m_ok          (m_ok),
		.m_alloc_offset(m_alloc_offset),
		.m_free_count  (m_free_count)
	);

	assign m_tdata = {{M_PAD_W{1'b0}}, m_free_count, m_alloc_offset, m_ok};

	assign step_cmds = {dp_cmd.touch, dp_cmd.mul, dp_cmd.pop_start, dp_cmd.pop_finish,
		dp_cmd.chk_res, dp_cmd.div_start, dp_cmd.div_step, dp_cmd.push};

	`FBFLA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready, "request accepted while another is in flight")
	`FBFLA_ASSERT_NOW(a_one_step, clk, arst_n, 1'b1, $onehot0(step_cmds), "more than one datapath step issued")
	`FBFLA_ASSERT_NOW(a_idle_quiet, clk, arst_n, s_tready, !(dp_cmd.div_step || dp_cmd.push || dp_cmd.pop_finish || dp_cmd.out_load), "datapath step issued while idle")
	`FBFLA_ASSERT_NEXT(a_load_shows, clk, arst_n, dp_cmd.out_load, m_tvalid, "loaded result not presented")

endmodule

// File: verif/alloc_result_checker.sv
`timescale 1ns / 100ps

module alloc_result_checker import fbfla_pkg::*; #(
	parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// func [1:0], block_offset [25:2], zero fill above
	input  logic [S_DATA_W-1:0]   s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// ok [0], alloc_offset [24:1], free_count [33:25], zero fill above
	input  logic [M_DATA_W-1:0]   m_tdata,
	output int                    mismatches,
	output int                    pending
);

	typedef struct packed {
		logic [CNT_W-1:0] free_count;
		logic [OFF_W-1:0] offset;
		logic             ok;
	} alloc_result_t;

	logic [CNT_W-1:0]  reg_blocks;
	logic [SIZE_W-1:0] reg_size;
	logic [CNT_W-1:0]  next_free [POOL_DEPTH];
	logic [CNT_W-1:0]  head;
	logic              head_ok;
	logic [CNT_W-1:0]  blocks_left;
	logic [CNT_W-1:0]  touched;
	alloc_result_t     expected_results [$];
	alloc_result_t     want;
	alloc_result_t     got;

	function automatic int unsigned usable_blocks();
		return (int'(reg_blocks) > POOL_DEPTH) ? POOL_DEPTH : int'(reg_blocks);
	endfunction

	function automatic void restart_pool();
		for (int i = 0; i < POOL_DEPTH; i++) begin
			next_free[i] = '0;
		end
		head = '0;
		head_ok = (usable_blocks() > 0);
		blocks_left = CNT_W'(usable_blocks());
		touched = '0;
	endfunction

	function automatic alloc_result_t serve_request(input logic [FUNC_W-1:0] kind,
			input logic [OFF_W-1:0] off);
		int unsigned n;
		int unsigned bs;
		int unsigned idx;
		longint unsigned span;
		alloc_result_t r;
		n = usable_blocks();
		bs = (reg_size == '0) ? 1 : int'(reg_size);
		r = '0;
		case (kind)
			FUNC_ALLOC: begin
				// The next untouched block is linked to its successor before the pop.
				if (touched < n) begin
					next_free[touched] = touched + 1'b1;
					touched = touched + 1'b1;
				end
				if (blocks_left != '0 && head_ok && head < n) begin
					r.ok = 1'b1;
					r.offset = OFF_W'(head * bs);
					blocks_left = blocks_left - 1'b1;
					if (blocks_left != '0 && next_free[head] < n) begin
						head = next_free[head];
					end else begin
						head_ok = 1'b0;
					end
				end
			end
			FUNC_FREE: begin
				idx = off / bs;
				if (idx < n && blocks_left < n) begin
					next_free[idx] = head_ok ? head : CNT_W'(n);
					head = CNT_W'(idx);
					head_ok = 1'b1;
					blocks_left = blocks_left + 1'b1;
					r.ok = 1'b1;
				end
			end
			FUNC_CHECK: begin
				span = longint'(n) * bs;
				r.ok = (off < span);
			end
			default: begin
			end
		endcase
		r.free_count = blocks_left;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_blocks = MAX_BLOCKS_RST;
			reg_size = BLOCK_SIZE_RST;
			restart_pool();
			expected_results.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MAX_BLOCKS: reg_blocks = cfg_data[CNT_W-1:0];
					REG_BLOCK_SIZE: reg_size = cfg_data;
					default: begin
					end
				endcase
				restart_pool();
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(serve_request(s_tdata[FUNC_W-1:0],
					s_tdata[FUNC_W +: OFF_W]));
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(alloc_result_t)-1:0];
				if (expected_results.size() == 0) begin
					if (mismatches < 10) begin
						$display("%0t: unexpected result word ok %0d offset %0h free %0d",
							$realtime, got.ok, got.offset, got.free_count);
					end
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (got.ok !== want.ok || got.offset !== want.offset
							|| got.free_count !== want.free_count) begin
						if (mismatches < 10) begin
							$display("%0t: result mismatch ok %0d/%0d offset %0h/%0h free %0d/%0d",
								$realtime, want.ok, got.ok, want.offset, got.offset,
								want.free_count, got.free_count);
						end
						mismatches++;
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
	import fbfla_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
	localparam int PHASES = 12;
	localparam int PHASE_WORDS = 150;
	localparam int HOLD_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_MAX_BLOCKS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	int                    mismatches;
	int                    pending;

	int          send_idle_pct = 0;
	int          stall_pct = 0;
	bit          pressure_go = 1'b0;
	int          hold_count = 0;
	int unsigned cur_blocks = 256;
	int unsigned cur_size = 64;

	logic [FUNC_W-1:0] sent_kinds [$];
	logic [FUNC_W-1:0] done_kind;
	logic [OFF_W-1:0]  live_offsets [$];

	int unsigned phase_blocks [PHASES] = '{256, 1, 8, 300, 17, 0, 2, 64, 256, 511, 3, 40};
	int unsigned phase_size [PHASES] = '{64, 4, 0, 65535, 100, 7, 5, 4096, 1, 65535, 65535, 12};

	fixed_block_free_list_allocator_unit i_dut (.*);

	alloc_result_checker i_checker (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("Some tests failed");
		$finish;
	end

	always @(negedge clk) begin
		if (pressure_go && hold_count < HOLD_CYCLES) begin
			m_tready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Offsets of allocated blocks are kept so that most frees are well-formed.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sent_kinds.push_back(s_tdata[FUNC_W-1:0]);
			end
			if (m_tvalid && m_tready && sent_kinds.size() != 0) begin
				done_kind = sent_kinds.pop_front();
				if (done_kind == FUNC_ALLOC && m_tdata[0]) begin
					live_offsets.push_back(m_tdata[OFF_W:1]);
				end
			end
		end
	end

	task automatic send_word(input logic [FUNC_W-1:0] kind, input logic [OFF_W-1:0] off);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{S_PAD_W{1'b0}}, off, kind};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (16) @(negedge clk);
	endtask

	task automatic configure(input int unsigned blocks, input int unsigned bytes);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_MAX_BLOCKS;
		cfg_data <= CFG_DATA_W'(blocks);
		@(negedge clk);
		cfg_index <= REG_BLOCK_SIZE;
		cfg_data <= CFG_DATA_W'(bytes);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cur_blocks = (blocks[CNT_W-1:0] > POOL_DEPTH_DEF) ? POOL_DEPTH_DEF : blocks[CNT_W-1:0];
		cur_size = (bytes[SIZE_W-1:0] == '0) ? 1 : bytes[SIZE_W-1:0];
		live_offsets.delete();
	endtask

	function automatic logic [OFF_W-1:0] near_pool();
		return OFF_W'($urandom_range(0, cur_blocks * cur_size + cur_size));
	endfunction

	initial begin
		int unsigned pick;
		int unsigned k;
		logic [OFF_W-1:0] off;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Two blocks of four bytes: a free of a never-allocated block followed by
		// allocs corrupts the list.
		configure(2, 4);
		send_word(FUNC_ALLOC, '0);
		send_word(FUNC_FREE, 24'd7);
		send_word(FUNC_ALLOC, '0);
		send_word(FUNC_ALLOC, '0);
		send_word(FUNC_FREE, 24'd8);
		send_word(FUNC_FREE, 24'd0);
		send_word(FUNC_FREE, 24'd3);
		send_word(FUNC_ALLOC, '1);
		send_word(FUNC_CHECK, 24'd7);
		send_word(FUNC_CHECK, 24'd8);
		send_word(FUNC_CHECK, '1);
		send_word(FUNC_NONE, '1);
		settle();

		configure(0, 0);
		send_word(FUNC_ALLOC, '0);
		send_word(FUNC_FREE, '0);
		send_word(FUNC_CHECK, '0);
		settle();

		configure(511, 65535);
		send_word(FUNC_ALLOC, '0);
		send_word(FUNC_ALLOC, '0);
		send_word(FUNC_CHECK, '1);
		send_word(FUNC_CHECK, 24'd16776959);
		send_word(FUNC_FREE, 24'd65535);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 50;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 50;
				end
				default: begin
					send_idle_pct = 16;
					stall_pct = 16;
				end
			endcase
			configure(phase_blocks[p], phase_size[p]);
			if (p == 4) begin
				pressure_go = 1'b1;
			end
			for (int i = 0; i < PHASE_WORDS; i++) begin
				pick = $urandom_range(0, 99);
				off = OFF_W'($urandom());
				if (pick < 45) begin
					send_word(FUNC_ALLOC, off);
				end else if (pick < 80) begin
					if (live_offsets.size() != 0 && $urandom_range(0, 9) != 0) begin
						k = $urandom_range(0, live_offsets.size() - 1);
						off = live_offsets[k] + OFF_W'($urandom_range(0, cur_size - 1));
						live_offsets.delete(k);
					end else if ($urandom_range(0, 1) != 0) begin
						off = near_pool();
					end
					send_word(FUNC_FREE, off);
				end else if (pick < 95) begin
					if ($urandom_range(0, 1) != 0) begin
						off = near_pool();
					end
					send_word(FUNC_CHECK, off);
				end else begin
					send_word(FUNC_NONE, off);
				end
			end
			settle();
		end

		if (mismatches == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/fbfla_pkg.sv
design/fbfla_ram.sv
design/fbfla_dp.sv
design/fbfla_ctrl.sv
design/fixed_block_free_list_allocator_unit.sv
verif/alloc_result_checker.sv
verif/tb.sv
